[hw/rtl/integer_to_ascii_radix_formatter_top_defines.svh]
// Assertion helpers for the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_RADIX_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_FORMATTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ITOARF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("itoarf assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ITOARF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("itoarf assertion failed");

`endif

[hw/rtl/itoarf_pkg.sv]
package itoarf_pkg;

   // Conversion selector codes
   localparam logic [3:0] OP_S32 = 4'd0;
   localparam logic [3:0] OP_S64 = 4'd1;
   localparam logic [3:0] OP_U32 = 4'd2;
   localparam logic [3:0] OP_U64 = 4'd3;
   localparam logic [3:0] OP_HEX = 4'd4;
   localparam logic [3:0] OP_HEX8 = 4'd5;
   localparam logic [3:0] OP_PTR = 4'd6;
   localparam logic [3:0] OP_OCT = 4'd7;
   localparam logic [3:0] OP_BIN = 4'd8;

   localparam int OPCODE_W = 4;
   localparam int VALUE_W = 64;
   localparam int CHAR_W = 8;
   localparam int REQ_DATA_W = 72;

   // Digit register: 20 BCD digits cover a full 64-bit unsigned value
   localparam int DEC_DIGITS = 20;
   localparam int BCD_W = DEC_DIGITS * 4;
   localparam int NDIG_W = 6;
   localparam int ITER_W = 7;

   localparam logic [NDIG_W-1:0] NDIG_DEC = NDIG_W'(DEC_DIGITS);
   localparam logic [NDIG_W-1:0] NDIG_HEX = NDIG_W'(8);
   localparam logic [NDIG_W-1:0] NDIG_OCT = NDIG_W'(11);
   localparam logic [NDIG_W-1:0] NDIG_BIN = NDIG_W'(32);
   localparam logic [NDIG_W-1:0] NDIG_ONE = NDIG_W'(1);
   localparam logic [ITER_W-1:0] ITER_32 = ITER_W'(32);
   localparam logic [ITER_W-1:0] ITER_64 = ITER_W'(64);
   localparam logic [ITER_W-1:0] ITER_ONE = ITER_W'(1);

   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CH_X = 8'h78;
   localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;

   typedef struct packed {
      logic load;        // capture the request
      logic dd_step;     // one double-dabble shift
      logic strip;       // drop a leading zero digit
      logic emit_digit;
      logic emit_sep;    // '_'
      logic emit_pre1;   // '-' or '0'
      logic emit_pre2;   // 'x'
   } itoarf_cmd_type;

   typedef struct packed {
      logic op_valid;
      logic neg;
      logic is_ptr;
      logic is_dec;
      logic conv_done;
      logic can_strip;
      logic last_digit;
      logic sep_after;
      logic out_free;
   } itoarf_status_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
      logic [CHAR_W-1:0] c;
      case (d)
         4'hA: c = 8'h41;
         4'hB: c = 8'h42;
         4'hC: c = 8'h43;
         4'hD: c = 8'h44;
         4'hE: c = 8'h45;
         4'hF: c = 8'h46;
         default: c = CH_ZERO + {4'b0, d};
      endcase
      return c;
   endfunction

endpackage

[hw/rtl/itoarf_ctrl.sv]
module itoarf_ctrl
   import itoarf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  itoarf_status_type sts,
   output itoarf_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_PRE1,
      ST_PRE2,
      ST_CONV,
      ST_STRIP,
      ST_EMIT,
      ST_SEP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!sts.op_valid) begin
               state_in = ST_IDLE;
            end else if (sts.neg || sts.is_ptr) begin
               state_in = ST_PRE1;
            end else if (sts.is_dec) begin
               state_in = ST_CONV;
            end else begin
               state_in = ST_STRIP;
            end
         end
         ST_PRE1: begin
            if (sts.out_free) begin
               cmd.emit_pre1 = 1'b1;
               state_in = sts.is_ptr ? ST_PRE2 : ST_CONV;
            end
         end
         ST_PRE2: begin
            if (sts.out_free) begin
               cmd.emit_pre2 = 1'b1;
               state_in = ST_STRIP;
            end
         end
         ST_CONV: begin
            cmd.dd_step = 1'b1;
            if (sts.conv_done) begin
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (sts.can_strip) begin
               cmd.strip = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_digit = 1'b1;
               if (sts.last_digit) begin
                  state_in = ST_IDLE;
               end else if (sts.sep_after) begin
                  state_in = ST_SEP;
               end
            end
         end
         ST_SEP: begin
            if (sts.out_free) begin
               cmd.emit_sep = 1'b1;
               state_in = ST_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/itoarf_dp.sv]
module itoarf_dp
   import itoarf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [VALUE_W-1:0]  req_value,
   input  itoarf_cmd_type      cmd,
   output itoarf_status_type   sts,
   output logic [CHAR_W-1:0]   rsp_char,
   output logic                rsp_last,
   output logic                rsp_valid,
   input  logic                rsp_ready
);

   logic [OPCODE_W-1:0] op_ff, op_in;
   logic                neg_ff, neg_in;
   logic [VALUE_W-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic [NDIG_W-1:0]   ndig_ff, ndig_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                last_ff, last_in;
   logic                valid_ff, valid_in;

   logic [31:0]        lo;
   logic [31:0]        lo_neg;
   logic [VALUE_W-1:0] v_neg;
   logic [BCD_W-1:0]   dd_adj;
   logic [BCD_W-1:0]   bcd_shift;
   logic [3:0]         top_digit;
   logic [NDIG_W-1:0]  min_digits;
   logic               is_dec, is_oct, is_bin;

   assign lo = req_value[31:0];
   assign lo_neg = 32'd0 - lo;
   assign v_neg = 64'd0 - req_value;

   assign is_dec = (op_ff == OP_S32) || (op_ff == OP_S64) ||
                   (op_ff == OP_U32) || (op_ff == OP_U64);
   assign is_oct = (op_ff == OP_OCT);
   assign is_bin = (op_ff == OP_BIN);

   // Add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         dd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                       : bcd_ff[i*4 +: 4];
      end
   end

   // Digits sit left-aligned; width 1, 3 or 4 bits by radix
   always_comb begin
      if (is_bin) begin
         top_digit = {3'b0, bcd_ff[BCD_W-1]};
         bcd_shift = {bcd_ff[BCD_W-2:0], 1'b0};
      end else if (is_oct) begin
         top_digit = {1'b0, bcd_ff[BCD_W-1 -: 3]};
         bcd_shift = {bcd_ff[BCD_W-4:0], 3'b0};
      end else begin
         top_digit = bcd_ff[BCD_W-1 -: 4];
         bcd_shift = {bcd_ff[BCD_W-5:0], 4'b0};
      end
   end

   assign min_digits = ((op_ff == OP_HEX8) || (op_ff == OP_PTR)) ? NDIG_HEX : NDIG_ONE;

   always_comb begin
      sts.op_valid = (op_ff <= OP_BIN);
      sts.neg = neg_ff;
      sts.is_ptr = (op_ff == OP_PTR);
      sts.is_dec = is_dec;
      sts.conv_done = (iter_ff == ITER_ONE);
      sts.can_strip = (ndig_ff > min_digits) && (top_digit == 4'd0);
      sts.last_digit = (ndig_ff == NDIG_ONE);
      // '_' after a binary digit whose bit index is a nonzero multiple of four
      sts.sep_after = is_bin && (ndig_ff[1:0] == 2'b01) && (ndig_ff != NDIG_ONE);
      sts.out_free = !valid_ff || rsp_ready;
   end

   always_comb begin
      op_in = op_ff;
      neg_in = neg_ff;
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      ndig_in = ndig_ff;
      iter_in = iter_ff;
      char_in = char_ff;
      last_in = last_ff;
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.load) begin
         op_in = req_opcode;
         neg_in = 1'b0;
         bin_in = '0;
         bcd_in = '0;
         ndig_in = NDIG_DEC;
         iter_in = ITER_32;
         case (req_opcode)
            OP_S32: begin
               neg_in = lo[31];
               bin_in = {(lo[31] ? lo_neg : lo), 32'b0};
            end
            OP_S64: begin
               neg_in = req_value[VALUE_W-1];
               bin_in = req_value[VALUE_W-1] ? v_neg : req_value;
               iter_in = ITER_64;
            end
            OP_U32: begin
               bin_in = {lo, 32'b0};
            end
            OP_U64: begin
               bin_in = req_value;
               iter_in = ITER_64;
            end
            OP_HEX, OP_HEX8, OP_PTR: begin
               bcd_in = {lo, 48'b0};
               ndig_in = NDIG_HEX;
            end
            OP_OCT: begin
               bcd_in = {1'b0, lo, 47'b0};
               ndig_in = NDIG_OCT;
            end
            OP_BIN: begin
               bcd_in = {lo, 48'b0};
               ndig_in = NDIG_BIN;
            end
            default: begin
               ndig_in = ndig_ff;
            end
         endcase
      end
      if (cmd.dd_step) begin
         bcd_in = {dd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         iter_in = iter_ff - ITER_ONE;
      end
      if (cmd.strip || cmd.emit_digit) begin
         bcd_in = bcd_shift;
         ndig_in = ndig_ff - NDIG_ONE;
      end
      if (cmd.emit_digit || cmd.emit_sep || cmd.emit_pre1 || cmd.emit_pre2) begin
         valid_in = 1'b1;
         last_in = cmd.emit_digit && (ndig_ff == NDIG_ONE);
         if (cmd.emit_digit) begin
            char_in = hex_char(top_digit);
         end else if (cmd.emit_sep) begin
            char_in = CH_UNDER;
         end else if (cmd.emit_pre2) begin
            char_in = CH_X;
         end else begin
            char_in = neg_ff ? CH_MINUS : CH_ZERO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         iter_ff <= '0;
         ndig_ff <= '0;
         op_ff <= '0;
         neg_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         iter_ff <= iter_in;
         ndig_ff <= ndig_in;
         op_ff <= op_in;
         neg_ff <= neg_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_char = char_ff;
   assign rsp_last = last_ff;
   assign rsp_valid = valid_ff;

endmodule

[hw/rtl/integer_to_ascii_radix_formatter_top.sv]
// Integer to ASCII formatter. Each request beat carries a conversion selector and a
// 64-bit number. The block returns the number's text one character per response beat,
// most significant character first, with tlast on the final character. Selectors 0..8
// give signed/unsigned 32/64-bit decimal, minimal hex, hex padded to 8 digits, pointer
// ("0x" plus 8 hex digits), octal and binary with '_' between 4-bit groups. Selectors
// 9..15 produce no output. One request is in work at a time. Decimal runs a
// double-dabble converter one bit per cycle. It then drops leading zeros one digit
// per cycle, stops at the first nonzero digit or at the minimum digit count, and
// emits one character per cycle while the output register is free. The next
// request is taken while the last character still waits in the output register.
`include "integer_to_ascii_radix_formatter_top_defines.svh"

module integer_to_ascii_radix_formatter_top
   import itoarf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request: [3:0] opcode, [67:4] value, [71:68] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Response: [7:0] character
   output logic [CHAR_W-1:0]     rsp_tdata,
   output logic                  rsp_tlast,  // last_char
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready
);

   itoarf_cmd_type    cmd;
   itoarf_status_type sts;
   logic [3:0]        emit_vec;

   // Sequencer: load, optional prefix, conversion, zero strip, emit
   itoarf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Digit register, double-dabble unit and output register
   itoarf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_opcode (req_tdata[OPCODE_W-1:0]),
      .req_value  (req_tdata[OPCODE_W +: VALUE_W]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_char   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready)
   );

   // Every character source, one bit each
   assign emit_vec = {cmd.emit_digit, cmd.emit_sep, cmd.emit_pre1, cmd.emit_pre2};

   // A character is only written into a free output register
   `ITOARF_ASSERT_NOW(a_emit_free, |emit_vec, sts.out_free)
   // At most one character source per cycle
   `ITOARF_ASSERT_NOW(a_emit_one, 1'b1, $onehot0(emit_vec))
   // After taking a request the block is busy with it
   `ITOARF_ASSERT_NEXT(a_busy_after_load, req_tvalid && req_tready, !req_tready)

endmodule

[sim/tb_integer_to_ascii_radix_formatter_top.sv]
`timescale 1ns / 100ps

module tb_integer_to_ascii_radix_formatter_top;
   import itoarf_pkg::*;

   // Selectors 9..15 are unused; the block swallows them without output
   localparam logic [3:0] OP_FIRST_UNUSED = 4'd9;
   localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

   localparam int DIR_ROWS       = 25;
   localparam int RANDOM_ITEMS   = 255;
   localparam int CALM_ITEMS     = 60;    // closing stretch with no idling
   localparam int LONG_HOLD      = 400;   // receiver hold-off, cycles
   localparam int TAIL_CYCLES    = 150;   // > one 64-bit decimal conversion
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either side

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [3:0] opcode, [67:4] value, [71:68] zero
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CHAR_W-1:0]     rsp_tdata;        // [7:0] character
   logic                  rsp_tlast;        // last_char
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   always #6 clock = ~clock;

   integer_to_ascii_radix_formatter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // ---------------------------------------------------------------------
   // Formatter model: its own copy of the conversion state. Digits are
   // gathered least significant first, then read back in reverse.
   // ---------------------------------------------------------------------
   logic [63:0] conv_mag = '0;
   logic [7:0]  digit_buf [32];
   logic [5:0]  digit_cnt = '0;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_beat_t;

   char_beat_t pending_chars[$];   // characters still owed by the block, oldest first

   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   bit  calm           = 1'b0;     // no idling on either side once set
   bit  long_hold_req  = 1'b0;     // sender asks the receiver for one long hold-off

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      return (d < 4'd10) ? 8'("0") + 8'(d) : 8'("A") + 8'(d - 4'd10);
   endfunction

   function automatic void push_digit(input logic [7:0] ch);
      // store is 32 deep; the longest text (20 decimal digits) never fills it
      if (digit_cnt < 6'd32) begin
         digit_buf[digit_cnt[4:0]] = ch;
         digit_cnt = digit_cnt + 6'd1;
      end
   endfunction

   function automatic void gather_decimal(input logic [63:0] m);
      conv_mag  = m;
      digit_cnt = '0;
      do begin
         push_digit(8'("0") + 8'(conv_mag % 64'd10));
         conv_mag = conv_mag / 64'd10;
      end while (conv_mag != 0);
   endfunction

   // shift 3 for octal, 4 for hex; min_digits gives zero padding
   function automatic void gather_pow2(input logic [63:0] m, input int shift,
                                       input int min_digits);
      logic [3:0] mask;
      mask      = (shift == 3) ? 4'h7 : 4'hF;
      conv_mag  = m;
      digit_cnt = '0;
      do begin
         push_digit(digit_char(conv_mag[3:0] & mask));
         conv_mag = conv_mag >> shift;
      end while (conv_mag != 0 || int'(digit_cnt) < min_digits);
   endfunction

   function automatic string drain_digits();
      string s;
      s = "";
      for (int i = int'(digit_cnt) - 1; i >= 0; i--)
         s = $sformatf("%s%c", s, digit_buf[5'(i)]);
      return s;
   endfunction

   // Text the block owes for one request; empty for unused selectors
   function automatic string format_number(input logic [3:0] op, input logic [63:0] num);
      logic [31:0] lo32;
      string       s;
      int          top;
      lo32 = num[31:0];
      s    = "";
      case (op)
         OP_S32: begin
            if (lo32[31]) begin
               s = "-";
               // most negative value: the 32-bit negate wraps back to 2^31, still right
               gather_decimal({32'd0, 32'd0 - lo32});
            end else begin
               gather_decimal({32'd0, lo32});
            end
            s = {s, drain_digits()};
         end
         OP_S64: begin
            if (num[63]) begin
               s = "-";
               gather_decimal(64'd0 - num);
            end else begin
               gather_decimal(num);
            end
            s = {s, drain_digits()};
         end
         OP_U32: begin
            gather_decimal({32'd0, lo32});
            s = drain_digits();
         end
         OP_U64: begin
            gather_decimal(num);
            s = drain_digits();
         end
         OP_HEX: begin
            gather_pow2({32'd0, lo32}, 4, 1);
            s = drain_digits();
         end
         OP_HEX8: begin
            gather_pow2({32'd0, lo32}, 4, 8);
            s = drain_digits();
         end
         OP_PTR: begin
            gather_pow2({32'd0, lo32}, 4, 8);
            s = {"0x", drain_digits()};
         end
         OP_OCT: begin
            gather_pow2({32'd0, lo32}, 3, 1);
            s = drain_digits();
         end
         OP_BIN: begin
            // straight from the bits; digit store untouched
            if (lo32 == 0) begin
               s = "0";
            end else begin
               top = 31;
               while (top > 0 && !lo32[top]) top--;
               for (int i = top; i >= 0; i--) begin
                  s = {s, lo32[i] ? "1" : "0"};
                  if (i % 4 == 0 && i != 0) s = {s, "_"};
               end
            end
         end
         default: s = "";
      endcase
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Directed table. has_txt rows carry text read straight off the spec;
   // the rest go through format_number.
   // ---------------------------------------------------------------------
   typedef struct {
      logic [3:0]  op;
      logic [63:0] num;
      bit          has_txt;
      string       txt;
   } dir_row_t;

   dir_row_t dir_rows [DIR_ROWS];

   initial begin
      dir_rows = '{
         '{OP_S32,  64'h0000_0000_0000_0000, 1'b1, "0"},
         '{OP_S32,  64'h0000_0000_8000_0000, 1'b1, "-2147483648"},
         '{OP_S32,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "-1"},
         '{OP_S64,  64'h8000_0000_0000_0000, 1'b1, "-9223372036854775808"},
         '{OP_S64,  64'h7FFF_FFFF_FFFF_FFFF, 1'b1, "9223372036854775807"},
         '{OP_S64,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "-1"},
         '{OP_U32,  64'h0000_0000_FFFF_FFFF, 1'b1, "4294967295"},
         '{OP_U32,  64'hFFFF_FFFF_0000_0000, 1'b1, "0"},
         '{OP_U64,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "18446744073709551615"},
         '{OP_U64,  64'h0000_0000_0000_0000, 1'b1, "0"},
         '{OP_U64,  64'h0123_4567_89AB_CDEF, 1'b0, ""},
         '{OP_HEX,  64'h0000_0000_0000_0000, 1'b1, "0"},
         '{OP_HEX,  64'h1234_5678_FFFF_FFFF, 1'b1, "FFFFFFFF"},
         '{OP_HEX8, 64'h0000_0000_0000_0000, 1'b1, "00000000"},
         '{OP_HEX8, 64'h0000_0000_0000_001A, 1'b1, "0000001A"},
         '{OP_PTR,  64'h0000_0000_0000_0000, 1'b1, "0x00000000"},
         '{OP_PTR,  64'h0000_0000_DEAD_BEEF, 1'b1, "0xDEADBEEF"},
         '{OP_OCT,  64'h0000_0000_0000_0000, 1'b1, "0"},
         '{OP_OCT,  64'h0000_0000_FFFF_FFFF, 1'b1, "37777777777"},
         '{OP_BIN,  64'h0000_0000_0000_0000, 1'b1, "0"},
         '{OP_BIN,  64'h0000_0000_0000_0001, 1'b1, "1"},
         '{OP_BIN,  64'h0000_0000_0000_0010, 1'b1, "1_0000"},
         '{OP_BIN,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           "1111_1111_1111_1111_1111_1111_1111_1111"},
         '{OP_FIRST_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ""},
         '{OP_LAST_UNUSED,  64'h0000_0000_0000_0005, 1'b1, ""}
      };
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Offer one request and hold it until accepted, then book the characters it owes.
   // req_tready is read right after the edge, so it is the value the edge sampled.
   task automatic send_item(input logic [3:0] op, input logic [63:0] num,
                            input bit has_txt, input string txt);
      string text;
      req_tdata  <= {4'b0, num, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      text = format_number(op, num);
      if (has_txt) text = txt;
      for (int i = 0; i < text.len(); i++)
         pending_chars.push_back('{ch: text[i], last: (i == text.len() - 1)});
   endtask

   // Sender idle burst; valid stays up across back-to-back beats
   task automatic sender_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Value shapes that reach the interesting corners of every mode
   function automatic logic [63:0] random_value();
      logic [63:0] p;
      p = 64'd1;
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 99));
         2: return 64'd0 - 64'($urandom_range(1, 1000));       // small negatives
         3: return (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
         4: begin
            // decimal digit-count boundaries: 10^k and 10^k - 1
            repeat ($urandom_range(0, 19)) p = p * 64'd10;
            return p - 64'($urandom_range(0, 1));
         end
         default: return {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off on request so
   // the block backs up and stops taking requests.
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 13)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response checker and watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      char_beat_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected beat char 0x%02h last %0b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_tdata !== want.ch)
                  report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                            rsp_tdata, want.ch));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last_char %0b, want %0b (char 0x%02h)",
                                            rsp_tlast, want.last, want.ch));
            end
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("integer_to_ascii_radix_formatter_top verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus: directed table, then random requests with noise
   // ---------------------------------------------------------------------
   initial begin : req_side
      logic [3:0] op;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_item(dir_rows[i].op, dir_rows[i].num, dir_rows[i].has_txt, dir_rows[i].txt);
         sender_gap();
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // receiver stalls hard while the sender keeps offering
         if (n == 100) long_hold_req = 1'b1;
         // sender drains the block completely before going on
         if (n == 200) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_chars.size() != 0) @(posedge clock);
            @(posedge clock);
         end
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         // occasional unused selector: must vanish without output
         if ($urandom_range(0, 11) == 0) begin
            send_item(4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)),
                      {$urandom, $urandom}, 1'b0, "");
            sender_gap();
         end
         op = 4'($urandom_range(OP_S32, OP_BIN));
         send_item(op, random_value(), 1'b0, "");
         sender_gap();
      end

      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      // catch stray beats after the last expected one
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("integer_to_ascii_radix_formatter_top verification clean");
      else
         $display("integer_to_ascii_radix_formatter_top verification failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/itoarf_pkg.sv
hw/rtl/itoarf_ctrl.sv
hw/rtl/itoarf_dp.sv
hw/rtl/integer_to_ascii_radix_formatter_top.sv
sim/tb_integer_to_ascii_radix_formatter_top.sv
